### rtl/fac_pkg.sv
// shared types, constants and helpers of the approximate-equality compare
`timescale 1ns / 1ps
`default_nettype none
package fac_pkg;

   localparam int unsigned SIG_W     = 53;
   localparam int unsigned EXP_W     = 14;
   localparam int unsigned GUARD_W   = 57;
   localparam int unsigned ALN_W     = SIG_W + GUARD_W;
   localparam int unsigned DIFF_W    = ALN_W + 1;
   localparam int unsigned PROD_W    = 2 * SIG_W;
   localparam int unsigned SPLIT_W   = 27;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned STAGES    = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_EPS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_EPS = 8'd1;

   localparam logic [63:0] DOUBLE_EPS_RESET = 64'h3CB0_0000_0000_0000;
   localparam logic [31:0] SINGLE_EPS_RESET = 32'h3400_0000;

   localparam logic [3:0] DOUBLE_DIGITS = 4'd15;
   localparam logic [3:0] SINGLE_DIGITS = 4'd7;

   localparam int EMIN_DOUBLE = -1074;
   localparam int EMIN_SINGLE = -149;
   localparam int FRAC_DOUBLE = 52;
   localparam int FRAC_SINGLE = 23;

   localparam logic [63:0] INF_DOUBLE = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] INF_SINGLE = 64'h0000_0000_7F80_0000;

   // 10^-k as binary64 patterns
   localparam logic [63:0] TOL_DOUBLE [16] = '{
      64'h3FF0000000000000, 64'h3FB999999999999A, 64'h3F847AE147AE147B,
      64'h3F50624DD2F1A9FC, 64'h3F1A36E2EB1C432D, 64'h3EE4F8B588E368F1,
      64'h3EB0C6F7A0B5ED8D, 64'h3E7AD7F29ABCAF48, 64'h3E45798EE2308C3A,
      64'h3E112E0BE826D695, 64'h3DDB7CDFD9D7BDBB, 64'h3DA5FD7FE1796495,
      64'h3D719799812DEA11, 64'h3D3C25C268497682, 64'h3D06849B86A12B9B,
      64'h3CD203AF9EE75616
   };

   // same values rounded to binary32
   localparam logic [31:0] TOL_SINGLE [16] = '{
      32'h3F800000, 32'h3DCCCCCD, 32'h3C23D70A, 32'h3A83126F,
      32'h38D1B717, 32'h3727C5AC, 32'h358637BD, 32'h33D6BF95,
      32'h322BCC77, 32'h3089705F, 32'h2EDBE6FF, 32'h2D2FEBFF,
      32'h2B8CBCCC, 32'h29E12E13, 32'h283424DC, 32'h26901D7D
   };

   typedef logic signed [EXP_W-1:0] exp_type;

   // value = sig * 2^ex
   typedef struct packed {
      logic [SIG_W-1:0] sig;
      exp_type          ex;
   } unp_type;

   typedef struct packed {
      logic        sign;
      logic        ones;
      logic        fnz;
      logic [63:0] mag;
   } info_type;

   // item data that rides along the arithmetic stages
   typedef struct packed {
      logic        early;
      logic        early_val;
      logic        single;
      logic        rel_ok;
      logic        rel_inf;
      logic [63:0] tol;
   } side_type;

   function automatic info_type fp_info(input logic [63:0] p, input logic single);
      info_type f;
      if (single) begin
         f.sign = p[31];
         f.ones = (p[30:23] == 8'hFF);
         f.fnz  = |p[22:0];
         f.mag  = {33'b0, p[30:0]};
      end else begin
         f.sign = p[63];
         f.ones = (p[62:52] == 11'h7FF);
         f.fnz  = |p[51:0];
         f.mag  = {1'b0, p[62:0]};
      end
      return f;
   endfunction

   function automatic unp_type unpack(input logic [63:0] p, input logic single);
      unp_type u;
      logic [10:0] ed;
      logic [7:0] es;
      ed = p[62:52];
      es = p[30:23];
      if (single) begin
         u.sig = {(es != 8'd0), p[22:0], 29'b0};
         u.ex  = exp_type'({6'b0, (es == 8'd0) ? 8'd1 : es}) - exp_type'(179);
      end else begin
         u.sig = {(ed != 11'd0), p[51:0]};
         u.ex  = exp_type'({3'b0, (ed == 11'd0) ? 11'd1 : ed}) - exp_type'(1075);
      end
      return u;
   endfunction

endpackage
`default_nettype wire

### rtl/fac_intf.sv
// channel interfaces: request, response and register write
`timescale 1ns / 1ps
`default_nettype none
interface fac_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [63:0] operand_a;
   logic [63:0] operand_b;
   logic [7:0]  digit_count;
   modport source (output valid, req_type, operand_a, operand_b, digit_count, input ready);
   modport sink (input valid, req_type, operand_a, operand_b, digit_count, output ready);
endinterface

interface fac_rsp_if;
   logic valid;
   logic ready;
   logic is_close;
   modport source (output valid, is_close, input ready);
   modport sink (input valid, is_close, output ready);
endinterface

interface fac_csr_if;
   import fac_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [63:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/fac_front.sv
// operand classification, unpacking and tolerance lookup (stage 1)
`timescale 1ns / 1ps
`default_nettype none
module fac_front #(
   parameter int unsigned TOL_TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              en,
   input  logic              req_type,
   input  logic [63:0]       operand_a,
   input  logic [63:0]       operand_b,
   input  logic [7:0]        digit_count,
   input  logic [63:0]       double_eps,
   input  logic [31:0]       single_eps,
   output fac_pkg::unp_type  big_ff,
   output fac_pkg::unp_type  small_ff,
   output fac_pkg::unp_type  eps_ff,
   output logic              sub_ff,
   output fac_pkg::side_type side_ff
);
   import fac_pkg::*;

   localparam logic [3:0] TBL_LIM = 4'(TOL_TABLE_DEPTH - 1);

   logic        single;
   logic [63:0] pa, pb, pe;
   info_type    ia, ib, ie;
   unp_type     ua, ub;
   logic        equal, a_big;
   logic [3:0]  lim, idx;
   side_type    side_in;

   always_comb begin
      single = req_type;
      pa = single ? {32'b0, operand_a[31:0]} : operand_a;
      pb = single ? {32'b0, operand_b[31:0]} : operand_b;
      pe = single ? {32'b0, single_eps} : double_eps;
      ia = fp_info(pa, single);
      ib = fp_info(pb, single);
      ie = fp_info(pe, single);
      ua = unpack(pa, single);
      ub = unpack(pb, single);
      // +0 equals -0; NaN equals nothing
      equal = ((ia.mag == 64'd0) && (ib.mag == 64'd0)) ||
              ((pa == pb) && !(ia.ones && ia.fnz));
      a_big = (ia.mag >= ib.mag);
      if (single) begin
         lim = (SINGLE_DIGITS < TBL_LIM) ? SINGLE_DIGITS : TBL_LIM;
      end else begin
         lim = (DOUBLE_DIGITS < TBL_LIM) ? DOUBLE_DIGITS : TBL_LIM;
      end
      if (digit_count == 8'd0) begin
         idx = 4'd1;
      end else if (digit_count > {4'b0, lim}) begin
         idx = lim;
      end else begin
         idx = digit_count[3:0];
      end
      side_in.early     = equal || ia.ones || ib.ones;
      side_in.early_val = equal;
      side_in.single    = single;
      side_in.rel_ok    = !ie.sign && !(ie.ones && ie.fnz);
      side_in.rel_inf   = ie.ones && !ie.fnz;
      side_in.tol       = single ? {32'b0, TOL_SINGLE[idx]} : TOL_DOUBLE[idx];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         big_ff   <= a_big ? ua : ub;
         small_ff <= a_big ? ub : ua;
         eps_ff   <= unpack(pe, single);
         sub_ff   <= (ia.sign == ib.sign);
         side_ff  <= side_in;
      end
   end

endmodule
`default_nettype wire

### rtl/fac_exact.sv
// exact difference and product (stages 2 and 3)
`timescale 1ns / 1ps
`default_nettype none
module fac_exact (
   input  logic                         clock,
   input  logic                         en_align,
   input  logic                         en_sum,
   input  fac_pkg::unp_type             big,
   input  fac_pkg::unp_type             minor,
   input  fac_pkg::unp_type             eps,
   input  logic                         sub,
   output logic [fac_pkg::DIFF_W-1:0]   diff_m_ff,
   output fac_pkg::exp_type             diff_e_ff,
   output logic                         diff_st_ff,
   output logic [fac_pkg::PROD_W-1:0]   prod_m_ff,
   output fac_pkg::exp_type             prod_e_ff
);
   import fac_pkg::*;

   localparam int unsigned SH_W = $clog2(ALN_W + 1);
   localparam int unsigned HI_W = SIG_W - SPLIT_W;

   exp_type          dexp;
   logic [SH_W-1:0]  dsh;
   logic [ALN_W-1:0] ywide, yal, ymask;
   logic             yst;

   logic [ALN_W-1:0]           xa_ff, ya_ff;
   logic                       yst_ff, sub_ff;
   exp_type                    de_ff, pe_ff;
   logic [2*HI_W-1:0]          hh_ff;
   logic [HI_W+SPLIT_W-1:0]    hl_ff, lh_ff;
   logic [2*SPLIT_W-1:0]       ll_ff;
   logic [HI_W+SPLIT_W:0]      mid;

   always_comb begin
      dexp  = big.ex - minor.ex;
      dsh   = (dexp > exp_type'(ALN_W)) ? SH_W'(ALN_W) : dexp[SH_W-1:0];
      ywide = {minor.sig, {GUARD_W{1'b0}}};
      yal   = ywide >> dsh;
      ymask = ~({ALN_W{1'b1}} << dsh);
      yst   = |(ywide & ymask);
   end

   always_ff @(posedge clock) begin
      if (en_align) begin
         xa_ff  <= {big.sig, {GUARD_W{1'b0}}};
         ya_ff  <= yal;
         yst_ff <= yst;
         sub_ff <= sub;
         de_ff  <= big.ex - exp_type'(GUARD_W);
         hh_ff  <= eps.sig[SIG_W-1:SPLIT_W] * big.sig[SIG_W-1:SPLIT_W];
         hl_ff  <= eps.sig[SIG_W-1:SPLIT_W] * big.sig[SPLIT_W-1:0];
         lh_ff  <= eps.sig[SPLIT_W-1:0] * big.sig[SIG_W-1:SPLIT_W];
         ll_ff  <= eps.sig[SPLIT_W-1:0] * big.sig[SPLIT_W-1:0];
         pe_ff  <= eps.ex + big.ex;
      end
   end

   assign mid = {1'b0, hl_ff} + {1'b0, lh_ff};

   always_ff @(posedge clock) begin
      if (en_sum) begin
         // dropped low bits of the smaller operand are jammed into the sticky bit
         if (sub_ff) begin
            diff_m_ff <= {1'b0, xa_ff} - {1'b0, ya_ff} - DIFF_W'(yst_ff);
         end else begin
            diff_m_ff <= {1'b0, xa_ff} + {1'b0, ya_ff};
         end
         diff_e_ff  <= de_ff;
         diff_st_ff <= yst_ff;
         prod_m_ff  <= (PROD_W'(hh_ff) << (2 * SPLIT_W)) + (PROD_W'(mid) << SPLIT_W) +
                       PROD_W'(ll_ff);
         prod_e_ff  <= pe_ff;
      end
   end

endmodule
`default_nettype wire

### rtl/fac_round.sv
// round-to-nearest-even and pack into binary64 or binary32 magnitude (three stages)
`timescale 1ns / 1ps
`default_nettype none
module fac_round #(
   parameter int unsigned W = 111
) (
   input  logic             clock,
   input  logic             en_lead,
   input  logic             en_shift,
   input  logic             en_pack,
   input  logic [W-1:0]     m,
   input  fac_pkg::exp_type e,
   input  logic             st,
   input  logic             single,
   output logic [63:0]      mag_ff
);
   import fac_pkg::*;

   localparam int unsigned LW    = $clog2(W);
   localparam int unsigned EXT_W = W + SIG_W + 1;
   localparam int unsigned SH_W  = $clog2(EXT_W + 1);
   localparam int unsigned PK_W  = 68;

   logic [LW-1:0] lead;
   exp_type       q_in, qmin_a, shs;
   logic [SH_W-1:0] sh_in;

   logic [W-1:0]    ma_ff;
   logic            sta_ff, sga_ff, nza_ff;
   exp_type         qa_ff;
   logic [SH_W-1:0] sha_ff;

   logic [EXT_W-1:0] ext, y, lmask;

   logic [SIG_W:0] r0_ff;
   logic           rb_ff, stb_ff, sgb_ff, nzb_ff;
   exp_type        qb_ff;

   logic           inc;
   logic [SIG_W+1:0] r;
   exp_type        bexp;
   logic [PK_W-1:0] pk, infw;

   always_comb begin
      lead = '0;
      for (int i = 0; i < W; i++) begin
         if (m[i]) begin
            lead = LW'(i);
         end
      end
      qmin_a = single ? exp_type'(EMIN_SINGLE) : exp_type'(EMIN_DOUBLE);
      q_in = e + exp_type'({{(EXP_W-LW){1'b0}}, lead}) -
             (single ? exp_type'(FRAC_SINGLE) : exp_type'(FRAC_DOUBLE));
      if (q_in < qmin_a) begin
         q_in = qmin_a;
      end
      // shift leaves the round bit at position zero
      shs   = q_in - e + exp_type'(SIG_W);
      sh_in = (shs > exp_type'(EXT_W)) ? SH_W'(EXT_W) : shs[SH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en_lead) begin
         ma_ff  <= m;
         sta_ff <= st;
         sga_ff <= single;
         nza_ff <= |m;
         qa_ff  <= q_in;
         sha_ff <= sh_in;
      end
   end

   always_comb begin
      ext   = {ma_ff, {(SIG_W+1){1'b0}}};
      y     = ext >> sha_ff;
      lmask = ~({EXT_W{1'b1}} << sha_ff);
   end

   always_ff @(posedge clock) begin
      if (en_shift) begin
         r0_ff  <= y[SIG_W+1:1];
         rb_ff  <= y[0];
         stb_ff <= sta_ff | (|(ext & lmask));
         sgb_ff <= sga_ff;
         nzb_ff <= nza_ff;
         qb_ff  <= qa_ff;
      end
   end

   always_comb begin
      inc  = rb_ff & (stb_ff | r0_ff[0]);
      r    = {1'b0, r0_ff} + (SIG_W+2)'(inc);
      bexp = qb_ff - (sgb_ff ? exp_type'(EMIN_SINGLE) : exp_type'(EMIN_DOUBLE));
      // a carry out of the significand bumps the exponent field through the add
      pk   = (PK_W'(unsigned'(bexp)) << (sgb_ff ? FRAC_SINGLE : FRAC_DOUBLE)) + PK_W'(r);
      infw = PK_W'(sgb_ff ? INF_SINGLE : INF_DOUBLE);
   end

   always_ff @(posedge clock) begin
      if (en_pack) begin
         if (!nzb_ff) begin
            mag_ff <= 64'd0;
         end else if (pk >= infw) begin
            mag_ff <= infw[63:0];
         end else begin
            mag_ff <= pk[63:0];
         end
      end
   end

endmodule
`default_nettype wire

### rtl/float_approx_equal_compare.sv
// Approximate-equality compare of two binary64 or binary32 numbers.
//
// req channel: one transfer carries req_type (0 double, 1 single), operand_a,
// operand_b and digit_count. In single mode only the low 32 bits are used.
// rsp channel: one transfer per request, in order, carrying is_close.
// csr channel: register 0 is the double epsilon pattern, register 1 the single
// epsilon pattern; other indexes are ignored. csr ready is always high.
// Throughput: one item per cycle when the receiver is not stalling; the seven
// pipeline stages (classify, align and partial products, add and product sum,
// leading-one, shift, round/pack, compare) each hold one item.
// Each stage advances when it is empty or its successor advances, so a stalled
// receiver fills the bubbles first and only then drops req ready.
// Reset clears all stage valid bits and loads the epsilon reset patterns.
`timescale 1ns / 1ps
`default_nettype none
module float_approx_equal_compare #(
   parameter int unsigned TOL_TABLE_DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   fac_req_if.sink   req_if,
   fac_rsp_if.source rsp_if,
   fac_csr_if.sink   csr_if
);
   import fac_pkg::*;

   logic [63:0] double_eps_ff;
   logic [31:0] single_eps_ff;

   logic [STAGES:1] v_ff;
   logic [STAGES:1] en;

   unp_type big1, small1, eps1;
   logic    sub1;
   side_type side1;
   side_type side_ff [2:STAGES-1];

   logic [DIFF_W-1:0] diff_m;
   exp_type           diff_e, prod_e;
   logic              diff_st;
   logic [PROD_W-1:0] prod_m;
   logic [63:0]       diff_mag, rel_mag, tol_eff;
   logic              use_rel;
   logic              is_close_ff;

   always_comb begin
      en[STAGES] = !v_ff[STAGES] | rsp_if.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] | en[k+1];
      end
   end

   assign req_if.ready = en[1];
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = v_ff[STAGES];
   assign rsp_if.is_close = is_close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff          <= '0;
         double_eps_ff <= DOUBLE_EPS_RESET;
         single_eps_ff <= SINGLE_EPS_RESET;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_if.valid;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (csr_if.valid && (csr_if.index == CSR_DOUBLE_EPS)) begin
            double_eps_ff <= csr_if.data;
         end
         if (csr_if.valid && (csr_if.index == CSR_SINGLE_EPS)) begin
            single_eps_ff <= csr_if.data[31:0];
         end
      end
   end

   fac_front #(
      .TOL_TABLE_DEPTH(TOL_TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .en         (en[1]),
      .req_type   (req_if.req_type),
      .operand_a  (req_if.operand_a),
      .operand_b  (req_if.operand_b),
      .digit_count(req_if.digit_count),
      .double_eps (double_eps_ff),
      .single_eps (single_eps_ff),
      .big_ff     (big1),
      .small_ff   (small1),
      .eps_ff     (eps1),
      .sub_ff     (sub1),
      .side_ff    (side1)
   );

   always_ff @(posedge clock) begin
      if (en[2]) begin
         side_ff[2] <= side1;
      end
      for (int k = 3; k <= STAGES - 1; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   fac_exact u_exact (
      .clock     (clock),
      .en_align  (en[2]),
      .en_sum    (en[3]),
      .big       (big1),
      .minor     (small1),
      .eps       (eps1),
      .sub       (sub1),
      .diff_m_ff (diff_m),
      .diff_e_ff (diff_e),
      .diff_st_ff(diff_st),
      .prod_m_ff (prod_m),
      .prod_e_ff (prod_e)
   );

   fac_round #(
      .W(DIFF_W)
   ) u_round_diff (
      .clock   (clock),
      .en_lead (en[4]),
      .en_shift(en[5]),
      .en_pack (en[6]),
      .m       (diff_m),
      .e       (diff_e),
      .st      (diff_st),
      .single  (side_ff[3].single),
      .mag_ff  (diff_mag)
   );

   fac_round #(
      .W(PROD_W)
   ) u_round_prod (
      .clock   (clock),
      .en_lead (en[4]),
      .en_shift(en[5]),
      .en_pack (en[6]),
      .m       (prod_m),
      .e       (prod_e),
      .st      (1'b0),
      .single  (side_ff[3].single),
      .mag_ff  (rel_mag)
   );

   always_comb begin
      // relative tolerance counts only when it is a non-negative number above
      // the absolute one
      use_rel = side_ff[6].rel_ok && (side_ff[6].rel_inf || (rel_mag > side_ff[6].tol));
      if (!use_rel) begin
         tol_eff = side_ff[6].tol;
      end else if (side_ff[6].rel_inf) begin
         tol_eff = side_ff[6].single ? INF_SINGLE : INF_DOUBLE;
      end else begin
         tol_eff = rel_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (en[STAGES]) begin
         is_close_ff <= side_ff[6].early ? side_ff[6].early_val : (diff_mag <= tol_eff);
      end
   end

endmodule
`default_nettype wire

### rtl/fac_checker.sv
// port-level checks of the compare pipeline, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fac_port_checks (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic is_close
);

   logic req_xfer;
   assign req_xfer = req_valid & req_ready;

   // an empty output stage means the whole pipeline can move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready while output stage is empty");

   // with the receiver ready in between, an accepted request shows up as a valid response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("response missing after pipeline latency");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(is_close))
      else $error("response payload changed while stalled");

endmodule

bind float_approx_equal_compare fac_port_checks u_fac_port_checks (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_if.valid),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .is_close (rsp_if.is_close)
);
`default_nettype wire
